@@ hdl/vau_pkg.sv @@
// ----------------------------------------------------------------------------
// vau_pkg
// Shared types, widths, operation codes and clamp helpers for the
// three-component fixed-point vector ALU.
// ----------------------------------------------------------------------------
package vau_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int WORD_W     = 32;
	localparam int OPND_W     = 33;  // multiplier operand (holds 1 - k)
	localparam int PROD_W     = 66;
	localparam int COMP_W     = 67;  // sum of two products
	localparam int SUM_W      = 68;  // sum of three components
	localparam int SSQ_W      = 64;  // sum of squares
	localparam int LEN_W      = 33;  // rounded length
	localparam int SQRT_STEPS = SSQ_W / 2;

	localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

	localparam logic signed [SUM_W-1:0] LIM_MAX = 68'sh0_0000_0000_7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] LIM_MIN = 68'shF_FFFF_FFFF_8000_0000;

	typedef enum logic [2:0] {
		FN_ADD    = 3'd0,
		FN_SUB    = 3'd1,
		FN_SCALE  = 3'd2,
		FN_DOT    = 3'd3,
		FN_CROSS  = 3'd4,
		FN_LERP   = 3'd5,
		FN_LENGTH = 3'd6,
		FN_NORM   = 3'd7
	} func_t;

	// per-word data that rides along behind the front arithmetic
	typedef struct packed {
		func_t                  func;
		logic [2:0][WORD_W-1:0] r;
		logic [WORD_W-1:0]      sc;
		logic                   sat;
		logic [2:0]             neg;
		logic [2:0][WORD_W-1:0] mag;
	} carry_t;

	typedef struct packed {
		carry_t           c;
		logic [SSQ_W-1:0] ssq;
	} front_t;

	typedef struct packed {
		logic [2:0][WORD_W-1:0] r;
		logic [WORD_W-1:0]      sc;
		logic                   sat;
		logic                   zl;
	} res_t;

	function automatic logic out_of_range(input logic signed [SUM_W-1:0] v);
		return (v > LIM_MAX) || (v < LIM_MIN);
	endfunction

	function automatic logic [WORD_W-1:0] clamp32(input logic signed [SUM_W-1:0] v);
		if (v > LIM_MAX)
			return WORD_MAX;
		else if (v < LIM_MIN)
			return WORD_MIN;
		return v[WORD_W-1:0];
	endfunction

endpackage

@@ hdl/vau_front.sv @@
// ----------------------------------------------------------------------------
// vau_front
// Front arithmetic: operand select, six shared multipliers, component sums,
// rounding and clamping for add/sub/scale/dot/cross/lerp, sum of squares.
// Six register stages (s1..s6).
// ----------------------------------------------------------------------------
module vau_front #(
	parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic [2:0]          func,
	input  logic signed [31:0]  ax,
	input  logic signed [31:0]  ay,
	input  logic signed [31:0]  az,
	input  logic signed [31:0]  bx,
	input  logic signed [31:0]  by,
	input  logic signed [31:0]  bz,
	input  logic signed [31:0]  k,
	output logic                out_v,
	output vau_pkg::front_t     out_f
);
	import vau_pkg::*;

	localparam logic signed [OPND_W-1:0] ONE_Q  = OPND_W'(1) << FRAC_BITS;
	localparam logic signed [COMP_W-1:0] HALF_C = COMP_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0]  HALF_S = SUM_W'(1) << (FRAC_BITS - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	func_t                     func_s1, func_s2, func_s3, func_s4, func_s5;
	logic signed [WORD_W-1:0]  a_s1 [3];
	logic signed [WORD_W-1:0]  a_s2 [3];
	logic signed [WORD_W-1:0]  a_s3 [3];
	logic signed [WORD_W-1:0]  a_s4 [3];
	logic signed [WORD_W-1:0]  a_s5 [3];
	logic signed [WORD_W-1:0]  b_s1 [3];
	logic signed [WORD_W-1:0]  k_s1;
	logic signed [PROD_W-1:0]  p_s2 [6];
	logic [2:0]                neg_s2;
	logic signed [COMP_W-1:0]  comp_s3 [3];
	logic signed [COMP_W-1:0]  rnd_s4 [3];
	logic signed [SUM_W-1:0]   sum_s4;
	logic [WORD_W-1:0]         vr_s5 [3];
	logic                      vsat_s5;
	logic signed [SUM_W-1:0]   drnd_s5;
	logic [SSQ_W-1:0]          ssq_s5;
	front_t                    f_s6;

	logic signed [OPND_W-1:0]  opx [6];
	logic signed [OPND_W-1:0]  opy [6];
	logic signed [PROD_W-1:0]  prod [6];
	logic [2:0]                neg_c;
	logic signed [OPND_W-1:0]  omk;
	logic                      vec_op;
	logic [WORD_W-1:0]         vr_c [3];
	logic                      vsat_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// operand select: component i uses products 2i and 2i+1
	always_comb begin
		omk   = ONE_Q - OPND_W'(k_s1);
		neg_c = '0;
		for (int i = 0; i < 3; i++) begin
			opx[2*i]   = OPND_W'(a_s1[i]);
			opy[2*i]   = ONE_Q;
			opx[2*i+1] = OPND_W'(b_s1[i]);
			opy[2*i+1] = ONE_Q;
			case (func_s1) inside
				FN_SUB: begin
					neg_c[i] = 1'b1;
				end
				FN_SCALE: begin
					opx[2*i]   = OPND_W'(k_s1);
					opy[2*i]   = OPND_W'(b_s1[i]);
					opx[2*i+1] = '0;
				end
				FN_DOT: begin
					opy[2*i]   = OPND_W'(b_s1[i]);
					opx[2*i+1] = '0;
				end
				FN_CROSS: begin
					opx[2*i]   = OPND_W'(a_s1[(i+1)%3]);
					opy[2*i]   = OPND_W'(b_s1[(i+2)%3]);
					opx[2*i+1] = OPND_W'(a_s1[(i+2)%3]);
					opy[2*i+1] = OPND_W'(b_s1[(i+1)%3]);
					neg_c[i]   = 1'b1;
				end
				FN_LERP: begin
					opy[2*i]   = omk;
					opx[2*i+1] = OPND_W'(k_s1);
					opy[2*i+1] = OPND_W'(b_s1[i]);
				end
				FN_LENGTH, FN_NORM: begin
					opy[2*i]   = OPND_W'(a_s1[i]);
					opx[2*i+1] = '0;
				end
				default: begin
				end
			endcase
		end
		for (int j = 0; j < 6; j++)
			prod[j] = PROD_W'(opx[j]) * PROD_W'(opy[j]);
	end

	// vector results are clamped for the vector ops only
	always_comb begin
		case (func_s4) inside
			FN_ADD, FN_SUB, FN_SCALE, FN_CROSS, FN_LERP: vec_op = 1'b1;
			default:                                     vec_op = 1'b0;
		endcase
		vsat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			vr_c[i] = vec_op ? clamp32(SUM_W'(rnd_s4[i])) : '0;
			vsat_c  = vsat_c | (vec_op & out_of_range(SUM_W'(rnd_s4[i])));
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: input word
			func_s1 <= func_t'(func);
			a_s1[0] <= ax;
			a_s1[1] <= ay;
			a_s1[2] <= az;
			b_s1[0] <= bx;
			b_s1[1] <= by;
			b_s1[2] <= bz;
			k_s1    <= k;
			// s2: products
			func_s2 <= func_s1;
			neg_s2  <= neg_c;
			for (int j = 0; j < 6; j++)
				p_s2[j] <= prod[j];
			// s3: component sums
			func_s3 <= func_s2;
			for (int i = 0; i < 3; i++)
				comp_s3[i] <= neg_s2[i] ? COMP_W'(p_s2[2*i]) - COMP_W'(p_s2[2*i+1])
				                        : COMP_W'(p_s2[2*i]) + COMP_W'(p_s2[2*i+1]);
			// s4: round half up, sum of the three components
			func_s4 <= func_s3;
			for (int i = 0; i < 3; i++)
				rnd_s4[i] <= (comp_s3[i] + HALF_C) >>> FRAC_BITS;
			sum_s4 <= SUM_W'(comp_s3[0]) + SUM_W'(comp_s3[1]) + SUM_W'(comp_s3[2]);
			// s5: vector clamp, dot rounding, sum of squares
			func_s5 <= func_s4;
			for (int i = 0; i < 3; i++)
				vr_s5[i] <= vr_c[i];
			vsat_s5 <= vsat_c;
			drnd_s5 <= (sum_s4 + HALF_S) >>> FRAC_BITS;
			ssq_s5  <= sum_s4[SSQ_W-1:0];
			// s6: dot clamp, magnitudes for normalize
			f_s6.c.func <= func_s5;
			for (int i = 0; i < 3; i++) begin
				f_s6.c.r[i]   <= vr_s5[i];
				f_s6.c.neg[i] <= a_s5[i][WORD_W-1];
				f_s6.c.mag[i] <= a_s5[i][WORD_W-1] ? WORD_W'(-a_s5[i]) : WORD_W'(a_s5[i]);
			end
			f_s6.c.sc  <= (func_s5 == FN_DOT) ? clamp32(drnd_s5) : '0;
			f_s6.c.sat <= vsat_s5 | ((func_s5 == FN_DOT) & out_of_range(drnd_s5));
			f_s6.ssq   <= ssq_s5;
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= a_s1[i];
				a_s3[i] <= a_s2[i];
				a_s4[i] <= a_s3[i];
				a_s5[i] <= a_s4[i];
			end
		end
	end

	assign out_v = v_s6;
	assign out_f = f_s6;

endmodule

@@ hdl/vau_root.sv @@
// ----------------------------------------------------------------------------
// vau_root
// Square root of the sum of squares (one result bit per stage), round to
// nearest, then three restoring dividers (one quotient bit per stage) for
// normalize, and final result select.
// ----------------------------------------------------------------------------
module vau_root #(
	parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  vau_pkg::front_t  in_f,
	output logic             out_v,
	output vau_pkg::res_t    out_r
);
	import vau_pkg::*;

	localparam int QB = FRAC_BITS + 1;           // quotient never exceeds 2^FRAC_BITS
	localparam int DW = LEN_W + FRAC_BITS + 1;   // dividend / remainder width

	typedef struct packed {
		carry_t           c;
		logic [SSQ_W-1:0] rem;
		logic [SSQ_W-1:0] rt;
	} sq_t;

	typedef struct packed {
		carry_t             c;
		logic [LEN_W-1:0]   len;
		logic [2:0][DW-1:0] rem;
		logic [2:0][QB-1:0] q;
	} dv_t;

	sq_t                   sq_s [SQRT_STEPS];
	logic [SQRT_STEPS-1:0] sq_v_s;
	sq_t                   sq_src [SQRT_STEPS];
	sq_t                   sq_nxt [SQRT_STEPS];
	carry_t                rd_c_s;
	logic [LEN_W-1:0]      rd_len_s;
	logic                  rd_v_s;
	dv_t                   np_s;
	logic                  np_v_s;
	dv_t                   dv_s [QB];
	logic [QB-1:0]         dv_v_s;
	dv_t                   dv_src [QB];
	dv_t                   dv_nxt [QB];
	res_t                  res_s;
	logic                  res_v_s;
	res_t                  res_c;
	dv_t                   last;

	// square root steps, one result bit each
	always_comb begin
		logic [SSQ_W:0]   trial;
		logic [SSQ_W-1:0] bitv;
		sq_src[0] = '{c: in_f.c, rem: in_f.ssq, rt: '0};
		for (int t = 1; t < SQRT_STEPS; t++)
			sq_src[t] = sq_s[t-1];
		for (int t = 0; t < SQRT_STEPS; t++) begin
			bitv      = SSQ_W'(1) << (SSQ_W - 2 - 2*t);
			trial     = {1'b0, sq_src[t].rt} + {1'b0, bitv};
			sq_nxt[t] = sq_src[t];
			if ({1'b0, sq_src[t].rem} >= trial) begin
				sq_nxt[t].rem = sq_src[t].rem - trial[SSQ_W-1:0];
				sq_nxt[t].rt  = (sq_src[t].rt >> 1) + bitv;
			end else begin
				sq_nxt[t].rt  = sq_src[t].rt >> 1;
			end
		end
	end

	// restoring divide steps, one quotient bit each
	always_comb begin
		logic [DW-1:0] sub;
		dv_src[0] = np_s;
		for (int t = 1; t < QB; t++)
			dv_src[t] = dv_s[t-1];
		for (int t = 0; t < QB; t++) begin
			dv_nxt[t] = dv_src[t];
			sub       = DW'(dv_src[t].len) << (QB - 1 - t);
			for (int i = 0; i < 3; i++) begin
				if (dv_src[t].rem[i] >= sub) begin
					dv_nxt[t].rem[i]         = dv_src[t].rem[i] - sub;
					dv_nxt[t].q[i][QB-1-t]   = 1'b1;
				end
			end
		end
	end

	// result select; normalize quotients stay within 2^FRAC_BITS, no clamp
	always_comb begin
		last     = dv_s[QB-1];
		res_c.r  = last.c.r;
		res_c.sc = last.c.sc;
		res_c.sat = last.c.sat;
		res_c.zl = 1'b0;
		case (last.c.func) inside
			FN_LENGTH: begin
				res_c.r   = '0;
				res_c.sat = last.len > LEN_W'(WORD_MAX);
				res_c.sc  = res_c.sat ? WORD_MAX : last.len[WORD_W-1:0];
			end
			FN_NORM: begin
				res_c.sc  = '0;
				res_c.sat = 1'b0;
				if (last.len == '0) begin
					res_c.r  = '0;
					res_c.zl = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++)
						res_c.r[i] = last.c.neg[i] ? -WORD_W'(last.q[i]) : WORD_W'(last.q[i]);
				end
			end
			default: begin
			end
		endcase
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s  <= '0;
			rd_v_s  <= 1'b0;
			np_v_s  <= 1'b0;
			dv_v_s  <= '0;
			res_v_s <= 1'b0;
		end else if (en) begin
			sq_v_s  <= {sq_v_s[SQRT_STEPS-2:0], in_v};
			rd_v_s  <= sq_v_s[SQRT_STEPS-1];
			np_v_s  <= rd_v_s;
			dv_v_s  <= {dv_v_s[QB-2:0], np_v_s};
			res_v_s <= dv_v_s[QB-1];
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < SQRT_STEPS; t++)
				sq_s[t] <= sq_nxt[t];
			// round to nearest, ties up
			rd_c_s   <= sq_s[SQRT_STEPS-1].c;
			rd_len_s <= LEN_W'(sq_s[SQRT_STEPS-1].rt) +
			            LEN_W'(sq_s[SQRT_STEPS-1].rem > sq_s[SQRT_STEPS-1].rt);
			// dividends mag * 2^F + len/2
			np_s.c   <= rd_c_s;
			np_s.len <= rd_len_s;
			np_s.q   <= '0;
			for (int i = 0; i < 3; i++)
				np_s.rem[i] <= (DW'(rd_c_s.mag[i]) << FRAC_BITS) + DW'(rd_len_s >> 1);
			for (int t = 0; t < QB; t++)
				dv_s[t] <= dv_nxt[t];
			res_s <= res_c;
		end
	end

	assign out_v = res_v_s;
	assign out_r = res_s;

endmodule

@@ hdl/vec3_arith_unit.sv @@
// Default format Q16.16. Throughput: one word per cycle while the skid entry
// is free; depth is set by the 32-step square root and the FRAC_BITS+1 step
// normalize divider, one step per stage.
// A two-entry output buffer (output register plus skid) decouples out_stall.
// Reset clears only valid bits and buffer state; payload registers are not reset.
// ----------------------------------------------------------------------------
// vec3_arith_unit
// Three-component Q-format vector ALU: add, sub, scale, dot, cross, lerp,
// length and normalize, with saturation and zero-vector flags.
// ----------------------------------------------------------------------------
module vec3_arith_unit #(
	parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] k,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic signed [31:0] scalar_out,
	output logic               saturated,
	output logic               zero_length
);
	import vau_pkg::*;

	logic   en;
	logic   front_v;
	front_t front_f;
	logic   pipe_v;
	res_t   pipe_r;
	logic   load_out;
	res_t   out_q;
	logic   out_valid_q;
	res_t   skid_q;
	logic   skid_full_q;

	// whole pipe advances while the skid entry is free
	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	vau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_valid),
		.func   (func),
		.ax     (ax),
		.ay     (ay),
		.az     (az),
		.bx     (bx),
		.by     (by),
		.bz     (bz),
		.k      (k),
		.out_v  (front_v),
		.out_f  (front_f)
	);

	vau_root #(.FRAC_BITS(FRAC_BITS)) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (front_v),
		.in_f   (front_f),
		.out_v  (pipe_v),
		.out_r  (pipe_r)
	);

	// output register takes the skid word first, else the pipe word
	assign load_out = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (load_out) begin
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid_q <= pipe_v;
			end
		end else if (pipe_v && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= skid_full_q ? skid_q : pipe_r;
		else if (!skid_full_q)
			skid_q <= pipe_r;
	end

	assign out_valid   = out_valid_q;
	assign rx          = $signed(out_q.r[0]);
	assign ry          = $signed(out_q.r[1]);
	assign rz          = $signed(out_q.r[2]);
	assign scalar_out  = $signed(out_q.sc);
	assign saturated   = out_q.sat;
	assign zero_length = out_q.zl;

endmodule

@@ hdl/vau_checker.sv @@
// ----------------------------------------------------------------------------
// vau_checker
// Port-level checks for vec3_arith_unit, attached by bind.
// ----------------------------------------------------------------------------
module vau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [2:0]         func,
	input logic signed [31:0] ax,
	input logic signed [31:0] ay,
	input logic signed [31:0] az,
	input logic signed [31:0] bx,
	input logic signed [31:0] by,
	input logic signed [31:0] bz,
	input logic signed [31:0] k,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] rx,
	input logic signed [31:0] ry,
	input logic signed [31:0] rz,
	input logic signed [31:0] scalar_out,
	input logic               saturated,
	input logic               zero_length
);
	import vau_pkg::*;

	logic [7:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 8'(in_acc) - 8'(out_acc);
	end

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rx) && $stable(ry) && $stable(rz)
			&& $stable(scalar_out) && $stable(saturated) && $stable(zero_length))
		else $error("stalled result word changed");

	// no result word without an accepted input word
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 8'd0)
		else $error("result word with nothing in flight");

	// input only stalls while a result word is pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// zero-vector normalize gives all zeros and no saturation
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> rx == 32'sd0 && ry == 32'sd0 && rz == 32'sd0
			&& scalar_out == 32'sd0 && !saturated)
		else $error("zero_length word has nonzero fields");

	// saturation leaves at least one field at a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> rx == $signed(WORD_MAX) || rx == $signed(WORD_MIN)
			|| ry == $signed(WORD_MAX) || ry == $signed(WORD_MIN)
			|| rz == $signed(WORD_MAX) || rz == $signed(WORD_MIN)
			|| scalar_out == $signed(WORD_MAX) || scalar_out == $signed(WORD_MIN))
		else $error("saturated word without a clamped field");

endmodule

bind vec3_arith_unit vau_checker u_vau_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the vector ALU against a local predictor of each operation: directed
// extremes and special cases, then random words with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
	import vau_pkg::*;

	localparam int FB = 16;
	localparam int LAT = 43 + FB;
	localparam int N_RAND = 1650;
	localparam longint LIMIT = 2000000;

	typedef struct {
		func_t func;
		logic signed [31:0] ax, ay, az, bx, by, bz, k;
	} op_word_t;

	typedef struct {
		logic signed [31:0] rx, ry, rz, sc;
		logic sat, zl;
	} vec_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] func = '0;
	logic signed [31:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0, k = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] rx, ry, rz, scalar_out;
	logic saturated, zero_length;

	op_word_t pending_q[$];
	vec_res_t expected_q[$];
	int errors = 0;
	longint cycles = 0;
	bit stim_done = 1'b0;
	int in_gap = 0;
	int out_hold = 0;

	vec3_arith_unit #(.FRAC_BITS(FB)) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly no gap, often short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// round-half-up reduction of a value carrying 2*FB fraction bits
	function automatic logic signed [127:0] round_q(input logic signed [127:0] p);
		return (p + (128'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
		inout logic sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// rounded square root, ties upward
	function automatic logic [63:0] root_round(input logic [63:0] n);
		logic [127:0] lo, hi, mid, n2;
		lo = 0;
		hi = 128'd4294967296;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		// round up when n > lo^2 + lo
		n2 = n;
		if (n2 > lo * lo + lo) lo = lo + 1;
		return lo[63:0];
	endfunction

	function automatic vec_res_t predict_vec(input op_word_t w);
		vec_res_t e;
		logic signed [127:0] a[3], b[3], kk, s, one;
		logic [63:0] ssq, len;
		logic [127:0] mag, q;
		int j, m;
		e = '{default: '0};
		a[0] = w.ax; a[1] = w.ay; a[2] = w.az;
		b[0] = w.bx; b[1] = w.by; b[2] = w.bz;
		kk = w.k;
		one = 128'sd1 <<< FB;
		ssq = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
		case (w.func)
			FN_ADD, FN_SUB, FN_SCALE, FN_CROSS, FN_LERP: begin
				for (int i = 0; i < 3; i++) begin
					j = (i + 1) % 3;
					m = (i + 2) % 3;
					case (w.func)
						FN_ADD: s = a[i] + b[i];
						FN_SUB: s = a[i] - b[i];
						FN_SCALE: s = round_q(kk * b[i]);
						FN_CROSS: s = round_q(a[j] * b[m] - a[m] * b[j]);
						default: s = round_q(a[i] * (one - kk) + kk * b[i]);
					endcase
					if (i == 0) e.rx = clamp_word(s, e.sat);
					else if (i == 1) e.ry = clamp_word(s, e.sat);
					else e.rz = clamp_word(s, e.sat);
				end
			end
			FN_DOT: e.sc = clamp_word(round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), e.sat);
			FN_LENGTH: e.sc = clamp_word($signed({64'd0, root_round(ssq)}), e.sat);
			default: begin
				if (ssq == 0) e.zl = 1'b1;
				else begin
					len = root_round(ssq);
					for (int i = 0; i < 3; i++) begin
						mag = (a[i] < 0) ? -a[i] : a[i];
						q = ((mag << FB) + (len >> 1)) / len;
						s = (a[i] < 0) ? -$signed(q) : $signed(q);
						if (i == 0) e.rx = clamp_word(s, e.sat);
						else if (i == 1) e.ry = clamp_word(s, e.sat);
						else e.rz = clamp_word(s, e.sat);
					end
				end
			end
		endcase
		return e;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycles);
	endtask

	function automatic logic signed [31:0] rand_field(input int mode);
		case (mode)
			0: return $urandom();
			1: return $signed(32'($urandom_range(0, 32'h3_FFFF))) - 32'sh2_0000;
			2: return $signed(32'($urandom_range(0, 32'h3FF_FFFF))) - 32'sh200_0000;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 0;
					3: return 32'sh0001_0000;
					default: return -32'sh0001_0000;
				endcase
			end
		endcase
	endfunction

	function automatic op_word_t mk(input func_t f, input logic signed [31:0] x,
		input logic signed [31:0] y, input logic signed [31:0] z,
		input logic signed [31:0] u, input logic signed [31:0] v,
		input logic signed [31:0] w, input logic signed [31:0] kv);
		op_word_t o;
		o.func = f; o.ax = x; o.ay = y; o.az = z;
		o.bx = u; o.by = v; o.bz = w; o.k = kv;
		return o;
	endfunction

	// stimulus
	initial begin
		op_word_t o;
		int mode;
		logic signed [31:0] mx, mn;
		mx = 32'sh7FFF_FFFF;
		mn = 32'sh8000_0000;
		pending_q.push_back(mk(FN_ADD, mx, mn, mx, mx, mn, 1, 0));
		pending_q.push_back(mk(FN_SUB, mn, mx, 0, mx, mn, 1, 0));
		pending_q.push_back(mk(FN_SCALE, 1, -1, mx, mx, mn, -1, mn));
		pending_q.push_back(mk(FN_SCALE, 0, 0, 0, 32'sh0000_8000, -32'sh8000, 1, 1));
		pending_q.push_back(mk(FN_DOT, mx, mx, mx, mx, mx, mx, 0));
		pending_q.push_back(mk(FN_DOT, mn, mn, mn, mx, mx, mx, 0));
		pending_q.push_back(mk(FN_CROSS, mx, mn, mx, mn, mx, mn, 0));
		pending_q.push_back(mk(FN_CROSS, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0, 0));
		pending_q.push_back(mk(FN_LERP, mx, mn, 0, mn, mx, 5, mn));
		pending_q.push_back(mk(FN_LERP, 10, 20, 30, 40, 50, 60, 32'sh8000));
		pending_q.push_back(mk(FN_LENGTH, mn, mn, mn, 0, 0, 0, 0));
		pending_q.push_back(mk(FN_LENGTH, 32'sh3_0000, 32'sh4_0000, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(FN_LENGTH, 0, 0, 0, mx, mx, mx, mx));
		pending_q.push_back(mk(FN_NORM, 0, 0, 0, mx, mn, 1, mx));
		pending_q.push_back(mk(FN_NORM, mn, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(FN_NORM, 1, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(FN_NORM, mx, mn, mx, 0, 0, 0, 0));
		pending_q.push_back(mk(FN_NORM, -3, 4, 0, 0, 0, 0, 0));
		for (int n = 0; n < N_RAND; n++) begin
			mode = $urandom_range(0, 3);
			o.func = func_t'($urandom_range(0, 7));
			o.ax = rand_field(mode); o.ay = rand_field(mode); o.az = rand_field(mode);
			o.bx = rand_field(mode); o.by = rand_field(mode); o.bz = rand_field(mode);
			o.k = rand_field(mode);
			pending_q.push_back(o);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk) begin
		op_word_t o;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_q.push_back(predict_vec(pending_q.pop_front()));
				in_gap = pick_gap();
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					o = pending_q[0];
					in_valid <= 1'b1;
					func <= o.func;
					ax <= o.ax; ay <= o.ay; az <= o.az;
					bx <= o.bx; by <= o.by; bz <= o.bz; k <= o.k;
				end else begin
					in_valid <= 1'b0;
					stim_done = 1'b1;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk) begin
		vec_res_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("UNEXPECTED result word at cycle %0d", cycles);
				end else begin
					e = expected_q.pop_front();
					if (rx !== e.rx) report_mismatch("rx", rx, e.rx);
					if (ry !== e.ry) report_mismatch("ry", ry, e.ry);
					if (rz !== e.rz) report_mismatch("rz", rz, e.rz);
					if (scalar_out !== e.sc) report_mismatch("scalar_out", scalar_out, e.sc);
					if (saturated !== e.sat)
						report_mismatch("saturated", 32'(saturated), 32'(e.sat));
					if (zero_length !== e.zl)
						report_mismatch("zero_length", 32'(zero_length), 32'(e.zl));
				end
			end
			if (out_hold > 0) begin
				out_hold--;
				out_stall <= 1'b1;
			end else begin
				out_hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
				out_stall <= (out_hold > 0);
			end
		end
	end

	// end of run and timeout
	initial begin
		int settle;
		settle = 0;
		while (1) begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
			if (stim_done && !in_valid && expected_q.size() == 0) settle++;
			else settle = 0;
			if (settle > 2 * LAT + 40) break;
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
